>>> rtl/pphba_pkg.sv
// pphba_pkg: shared widths, register codes and types for the point plotter.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package pphba_pkg;

    // Field widths
    localparam int COORD_W    = 24;   // point_x / point_y
    localparam int FRAC_BITS  = 8;    // fraction bits of a coordinate
    localparam int NUM_W      = 20;   // point_number
    localparam int ORIGIN_W   = 16;   // origin_left / origin_top
    localparam int DIM_W      = 13;   // frame_width / frame_height
    localparam int PIF_W      = 21;   // points_in_frame
    localparam int POS_W      = 12;   // pixel_column / pixel_row
    localparam int CHAN_W     = 8;    // one colour channel
    localparam int MAX_DIM    = 4096;

    // Coordinate after subtracting the origin, with one guard bit
    localparam int WHOLE_W    = COORD_W - FRAC_BITS;
    localparam int DELTA_W    = ORIGIN_W + 1;

    // Hue = num * 1536 / limit; 1536 = 3 << HUE_SHIFT, quotient below 1536
    localparam int HUE_SHIFT  = 9;
    localparam int HUE_W      = 11;
    localparam int N3_W       = NUM_W + 2;          // num * 3
    localparam int BRING_W    = HUE_W - HUE_SHIFT;  // dividend bits below the first remainder
    localparam int DIV_STAGES = HUE_W;              // one quotient bit per stage

    // Configuration channel
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_LEFT     = 3'd0,
        REG_ORIGIN_TOP      = 3'd1,
        REG_FRAME_WIDTH     = 3'd2,
        REG_FRAME_HEIGHT    = 3'd3,
        REG_COLOUR_MODE     = 3'd4,
        REG_POINTS_IN_FRAME = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

>>> rtl/pphba_if.sv
// pphba_if: valid/ready channel interfaces for points, pixels and config writes.
// Depends on pphba_pkg for field widths.
`default_nettype none

interface pphba_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [pphba_pkg::COORD_W-1:0] point_x;
    logic signed [pphba_pkg::COORD_W-1:0] point_y;
    logic        [pphba_pkg::NUM_W-1:0]   point_number;

    modport source (output valid, point_x, point_y, point_number, input ready);
    modport sink   (input valid, point_x, point_y, point_number, output ready);
endinterface

interface pphba_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [pphba_pkg::POS_W-1:0]   pixel_column;
    logic [pphba_pkg::POS_W-1:0]   pixel_row;
    logic [pphba_pkg::CHAN_W-1:0]  red;
    logic [pphba_pkg::CHAN_W-1:0]  green;
    logic [pphba_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, pixel_column, pixel_row, red, green, blue, input ready);
    modport sink   (input valid, pixel_column, pixel_row, red, green, blue, output ready);
endinterface

interface pphba_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pphba_pkg::CFG_IDX_W-1:0]   index;
    logic [pphba_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/pphba_colour.sv
// pphba_colour: maps a hue position (1/256 sector units) to full-saturation RGB.
// Depends on pphba_pkg (rgb_t, widths). Mono mode forces white.
`default_nettype none

module pphba_colour (
    input  wire logic [pphba_pkg::HUE_W-1:0] hue,
    input  wire logic                        colour_mode,
    output pphba_pkg::rgb_t                  rgb
);

    logic [2:0]                   sector;
    logic [pphba_pkg::CHAN_W-1:0] frac;
    logic [pphba_pkg::CHAN_W-1:0] ramp;

    localparam logic [pphba_pkg::CHAN_W-1:0] FULL = '1;
    localparam logic [pphba_pkg::CHAN_W-1:0] NONE = '0;

    assign sector = hue[pphba_pkg::HUE_W-1:pphba_pkg::CHAN_W];
    assign frac   = hue[pphba_pkg::CHAN_W-1:0];

    // floor(255*f/256) is f-1 (0 at f=0); floor(255*(256-f)/256) is 255-f
    always_comb
    begin
        if (sector[0])
        begin
            ramp = FULL - frac;
        end
        else if (frac == NONE)
        begin
            ramp = NONE;
        end
        else
        begin
            ramp = frac - 8'd1;
        end
    end

    always_comb
    begin
        if (!colour_mode)
        begin
            rgb = '{red: FULL, green: FULL, blue: FULL};
        end
        else
        begin
            case (sector)
                3'd0:    rgb = '{red: FULL, green: ramp, blue: NONE};
                3'd1:    rgb = '{red: ramp, green: FULL, blue: NONE};
                3'd2:    rgb = '{red: NONE, green: FULL, blue: ramp};
                3'd3:    rgb = '{red: NONE, green: ramp, blue: FULL};
                3'd4:    rgb = '{red: ramp, green: NONE, blue: FULL};
                default: rgb = '{red: FULL, green: NONE, blue: ramp};
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/point_plot_hue_by_age.sv
// point_plot_hue_by_age: top level of the point plotter with age-based hue.
// Depends on pphba_pkg, pphba_if (channel interfaces) and pphba_colour.
`default_nettype none

// Usage
//   cfg    : register writes (index, data); always ready. Write only while the
//            pipeline is empty. Index 0..5 = origin_left, origin_top,
//            frame_width, frame_height, colour_mode, points_in_frame.
//   points : one point per transfer (point_x, point_y, point_number).
//   pixels : one pixel write per plotted point; points outside the frame or
//            with point_number >= points_in_frame produce no transfer.
// Timing
//   From point transfer to pixels.valid a point passes through one entry stage
//   (floor, origin subtract, bounds and index checks, num*3), eleven
//   restoring-divider stages that each resolve one hue quotient bit against
//   points_in_frame, then the color map into the output register. Throughput
//   is one point per cycle while pixels.ready is high; the divider sets the depth.
// Stall
//   Each stage holds while its successor is full and stalled; empty stages
//   (dropped points) are filled in, so points.ready stays high until every
//   stage holds an item and pixels.ready is low.
// Reset
//   rst_n low clears all stage valid bits and the config registers to zero.

module point_plot_hue_by_age (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pphba_cfg_if.sink       cfg,
    pphba_point_if.sink     points,
    pphba_pixel_if.source   pixels
);

    localparam int NS = pphba_pkg::DIV_STAGES;

    // Divider stage payload
    typedef struct packed {
        logic [pphba_pkg::PIF_W-1:0]   rem;
        logic [pphba_pkg::HUE_W-1:0]   quo;
        logic [pphba_pkg::BRING_W-1:0] bring;
        logic [pphba_pkg::POS_W-1:0]   col;
        logic [pphba_pkg::POS_W-1:0]   row;
    } div_stage_t;

    // ---------------- configuration registers ----------------
    logic signed [pphba_pkg::ORIGIN_W-1:0] origin_left_reg;
    logic signed [pphba_pkg::ORIGIN_W-1:0] origin_top_reg;
    logic        [pphba_pkg::DIM_W-1:0]    frame_width_reg;
    logic        [pphba_pkg::DIM_W-1:0]    frame_height_reg;
    logic                                  colour_mode_reg;
    logic        [pphba_pkg::PIF_W-1:0]    points_in_frame_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_left_reg     <= '0;
            origin_top_reg      <= '0;
            frame_width_reg     <= '0;
            frame_height_reg    <= '0;
            colour_mode_reg     <= 1'b0;
            points_in_frame_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (pphba_pkg::cfg_reg_t'(cfg.index))
                pphba_pkg::REG_ORIGIN_LEFT:
                    origin_left_reg <= cfg.data[pphba_pkg::ORIGIN_W-1:0];
                pphba_pkg::REG_ORIGIN_TOP:
                    origin_top_reg <= cfg.data[pphba_pkg::ORIGIN_W-1:0];
                pphba_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg.data[pphba_pkg::DIM_W-1:0];
                pphba_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg.data[pphba_pkg::DIM_W-1:0];
                pphba_pkg::REG_COLOUR_MODE:
                    colour_mode_reg <= cfg.data[0];
                pphba_pkg::REG_POINTS_IN_FRAME:
                    points_in_frame_reg <= cfg.data[pphba_pkg::PIF_W-1:0];
                default: ; // unknown index: ignored
            endcase
        end
    end

    // ---------------- stall chain ----------------
    logic          out_valid_reg;
    logic [NS:1]   div_valid_reg;
    logic          s0_valid_reg;
    logic [NS:1]   div_en;
    logic          out_en;
    logic          s0_en;

    always_comb
    begin
        out_en     = !out_valid_reg || pixels.ready;
        div_en[NS] = !div_valid_reg[NS] || out_en;
        for (int k = NS - 1; k >= 1; k--)
        begin
            div_en[k] = !div_valid_reg[k] || div_en[k+1];
        end
        s0_en = !s0_valid_reg || div_en[1];
    end

    assign points.ready = s0_en;

    // ---------------- entry stage ----------------
    // Arithmetic shift is the floor of the fixed-point value.
    logic signed [pphba_pkg::COORD_W-1:0] x_shift;
    logic signed [pphba_pkg::COORD_W-1:0] y_shift;
    logic signed [pphba_pkg::DELTA_W-1:0] col_delta;
    logic signed [pphba_pkg::DELTA_W-1:0] row_delta;
    logic        [pphba_pkg::DIM_W-1:0]   width_clamp;
    logic        [pphba_pkg::DIM_W-1:0]   height_clamp;
    logic                                 in_frame;
    logic                                 in_range;
    logic        [pphba_pkg::N3_W-1:0]    num_x3;

    logic [pphba_pkg::N3_W-1:0]  s0_n3_reg;
    logic [pphba_pkg::POS_W-1:0] s0_col_reg;
    logic [pphba_pkg::POS_W-1:0] s0_row_reg;

    always_comb
    begin
        x_shift   = points.point_x >>> pphba_pkg::FRAC_BITS;
        y_shift   = points.point_y >>> pphba_pkg::FRAC_BITS;
        col_delta = pphba_pkg::DELTA_W'(signed'(x_shift[pphba_pkg::WHOLE_W-1:0]))
                  - pphba_pkg::DELTA_W'(origin_left_reg);
        row_delta = pphba_pkg::DELTA_W'(signed'(y_shift[pphba_pkg::WHOLE_W-1:0]))
                  - pphba_pkg::DELTA_W'(origin_top_reg);

        width_clamp  = (frame_width_reg > pphba_pkg::DIM_W'(pphba_pkg::MAX_DIM))
                     ? pphba_pkg::DIM_W'(pphba_pkg::MAX_DIM) : frame_width_reg;
        height_clamp = (frame_height_reg > pphba_pkg::DIM_W'(pphba_pkg::MAX_DIM))
                     ? pphba_pkg::DIM_W'(pphba_pkg::MAX_DIM) : frame_height_reg;

        in_frame = !col_delta[pphba_pkg::DELTA_W-1]
                && !row_delta[pphba_pkg::DELTA_W-1]
                && (col_delta[pphba_pkg::DELTA_W-2:0]
                    < (pphba_pkg::DELTA_W-1)'(width_clamp))
                && (row_delta[pphba_pkg::DELTA_W-2:0]
                    < (pphba_pkg::DELTA_W-1)'(height_clamp));

        // a zero limit also fails this compare
        in_range = pphba_pkg::PIF_W'(points.point_number) < points_in_frame_reg;

        num_x3 = pphba_pkg::N3_W'(points.point_number)
               + {pphba_pkg::N3_W'(points.point_number) << 1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_en)
        begin
            s0_valid_reg <= points.valid && in_frame && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_en)
        begin
            s0_n3_reg  <= num_x3;
            s0_col_reg <= col_delta[pphba_pkg::POS_W-1:0];
            s0_row_reg <= row_delta[pphba_pkg::POS_W-1:0];
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    // Dividend is num_x3 << HUE_SHIFT; its top part is already below the divisor.
    div_stage_t div_reg  [1:NS];
    div_stage_t div_src  [1:NS];
    div_stage_t div_next [1:NS];

    always_comb
    begin
        logic [pphba_pkg::PIF_W:0] trial;
        logic                      take;

        div_src[1].rem   = pphba_pkg::PIF_W'(s0_n3_reg[pphba_pkg::N3_W-1:pphba_pkg::BRING_W]);
        div_src[1].quo   = '0;
        div_src[1].bring = s0_n3_reg[pphba_pkg::BRING_W-1:0];
        div_src[1].col   = s0_col_reg;
        div_src[1].row   = s0_row_reg;
        for (int k = 2; k <= NS; k++)
        begin
            div_src[k] = div_reg[k-1];
        end

        trial = '0;
        take  = 1'b0;
        for (int k = 1; k <= NS; k++)
        begin
            trial = {div_src[k].rem, div_src[k].bring[pphba_pkg::BRING_W-1]};
            take  = trial >= {1'b0, points_in_frame_reg};
            div_next[k].rem   = take
                              ? pphba_pkg::PIF_W'(trial - {1'b0, points_in_frame_reg})
                              : trial[pphba_pkg::PIF_W-1:0];
            div_next[k].quo   = {div_src[k].quo[pphba_pkg::HUE_W-2:0], take};
            div_next[k].bring = div_src[k].bring << 1;
            div_next[k].col   = div_src[k].col;
            div_next[k].row   = div_src[k].row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
        end
        else
        begin
            if (div_en[1])
            begin
                div_valid_reg[1] <= s0_valid_reg;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (div_en[k])
                begin
                    div_valid_reg[k] <= div_valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= NS; k++)
        begin
            if (div_en[k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ---------------- colour map and output register ----------------
    pphba_pkg::rgb_t             rgb_next;
    pphba_pkg::rgb_t             rgb_reg;
    logic [pphba_pkg::POS_W-1:0] col_reg;
    logic [pphba_pkg::POS_W-1:0] row_reg;

    pphba_colour u_colour (
        .hue         (div_reg[NS].quo),
        .colour_mode (colour_mode_reg),
        .rgb         (rgb_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= div_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            rgb_reg <= rgb_next;
            col_reg <= div_reg[NS].col;
            row_reg <= div_reg[NS].row;
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel_column = col_reg;
    assign pixels.pixel_row    = row_reg;
    assign pixels.red          = rgb_reg.red;
    assign pixels.green        = rgb_reg.green;
    assign pixels.blue         = rgb_reg.blue;

endmodule

`default_nettype wire

>>> rtl/pphba_checker.sv
// pphba_checker: port-level assertions for point_plot_hue_by_age, bound to the top.
// Depends on pphba_pkg; tracks frame width and colour mode from config transfers.
`default_nettype none

module pphba_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [pphba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [pphba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input wire logic                              pix_valid,
    input wire logic                              pix_ready,
    input wire logic [pphba_pkg::POS_W-1:0]       pix_column,
    input wire logic [pphba_pkg::POS_W-1:0]       pix_row,
    input wire logic [pphba_pkg::CHAN_W-1:0]      pix_red,
    input wire logic [pphba_pkg::CHAN_W-1:0]      pix_green,
    input wire logic [pphba_pkg::CHAN_W-1:0]      pix_blue
);

    localparam logic [pphba_pkg::CHAN_W-1:0] FULL = '1;
    localparam logic [pphba_pkg::CHAN_W-1:0] NONE = '0;

    logic [pphba_pkg::DIM_W-1:0] width_reg;
    logic                        mode_reg;
    logic [pphba_pkg::DIM_W:0]   width_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pphba_pkg::REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data[pphba_pkg::DIM_W-1:0];
            end
            if (cfg_index == pphba_pkg::REG_COLOUR_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    assign width_clamp = (width_reg > pphba_pkg::DIM_W'(pphba_pkg::MAX_DIM))
                       ? (pphba_pkg::DIM_W+1)'(pphba_pkg::MAX_DIM)
                       : (pphba_pkg::DIM_W+1)'(width_reg);

    // stalled pixel holds
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_column) && $stable(pix_row)
            && $stable(pix_red) && $stable(pix_green) && $stable(pix_blue))
        else $error("pixel changed while stalled");

    // column always inside the configured width
    a_col_inside: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> ((pphba_pkg::DIM_W+1)'(pix_column) < width_clamp))
        else $error("pixel column outside frame width");

    // mono mode writes white
    a_mono_white: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !mode_reg |-> pix_red == FULL && pix_green == FULL && pix_blue == FULL)
        else $error("mono pixel not white");

    // full saturation: one channel at full, one at zero
    a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && mode_reg |->
            (pix_red == FULL || pix_green == FULL || pix_blue == FULL)
            && (pix_red == NONE || pix_green == NONE || pix_blue == NONE))
        else $error("hue pixel not fully saturated");

endmodule

bind point_plot_hue_by_age pphba_checker u_pphba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .pix_valid  (pixels.valid),
    .pix_ready  (pixels.ready),
    .pix_column (pixels.pixel_column),
    .pix_row    (pixels.pixel_row),
    .pix_red    (pixels.red),
    .pix_green  (pixels.green),
    .pix_blue   (pixels.blue)
);

`default_nettype wire
